FILE: rtl/core/rv32_pkg.sv
`default_nettype none
package rv32_pkg;
  localparam int MEM_BYTES = 65536;
  localparam int MA_W = $clog2(MEM_BYTES);
  localparam int WA_W = MA_W - 2;
  localparam logic [31:0] MEM_BASE = 32'h1000_0000;

  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6F;

  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3,
                         F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_W = 3'd2;

  // output tdata layout, highest bit first
  typedef struct packed {
    logic [7:0]  pad;
    logic        unknown_op;
    logic        mem_written;
    logic [31:0] wb_value;
    logic [4:0]  wb_index;
    logic        wb_valid;
    logic [31:0] next_pc;
    logic [31:0] pc;
  } result_t;
endpackage
`default_nettype wire

FILE: rtl/core/rv32i_subset_instruction_step.sv
// Channel  | Dir | Payload (tdata, low bit first)
// s_axis   | in  | instr[31:0]
// m_axis   | out | pc, next_pc, wb_valid, wb_index, wb_value, mem_written, unknown_op, 8b pad
//
// One instruction per cycle while results are taken. Stage 1 reads the register file with
// forwarding from stage 2 and starts the data memory read, one address per
// byte lane; stage 2 finishes execute, writes back and loads the output register.
// A result passes from the stage-2 register into the output register. A store
// followed by a load forwards per byte lane. rst clears pc, register file valid
// bits and the pipeline.
// s_axis_tready drops while the output register holds an untaken result.
`default_nettype none
module rv32i_subset_instruction_step import rv32_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // instr
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata    // pc, next_pc, wb_valid, wb_index, wb_value,
                                            // mem_written, unknown_op, pad
);
  // register file: memory with reset valid bits
  logic [31:0] rf [32];
  logic [31:0] rf_vld;
  // data memory: four byte lanes, each read and written at its own word address
  logic [7:0] dm0 [MEM_BYTES/4];
  logic [7:0] dm1 [MEM_BYTES/4];
  logic [7:0] dm2 [MEM_BYTES/4];
  logic [7:0] dm3 [MEM_BYTES/4];

  logic [31:0] pc;
  // stage 2
  logic        v2;
  logic [31:0] ins2, pc2;
  logic [31:0] ra2, rb2;
  logic        fa2, fb2;      // rf entry valid
  logic [31:0] lw2;           // lane bytes as read
  logic [3:0]  fwm2;          // lanes replaced by a same-edge store
  logic [31:0] fwd2;          // store bytes for those lanes
  logic [1:0]  bo2;

  logic        advance, out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign advance  = out_free;
  assign s_axis_tready = advance && !rst;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // ---------------- stage 2 execute ----------------
  logic [6:0] op; logic [4:0] rd, rs1, rs2; logic [2:0] f3; logic [6:0] f7;
  logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, val, nxt, alu_b, sh_r;
  logic [32:0] sh_x;
  logic ok, wr, memw, taken, alt, isreg;
  logic [4:0] sh;
  logic [31:0] st_off;
  logic [31:0] ldv, lane_w;
  logic [63:0] ldpair;
  // writeback of stage 2 (for forwarding into the stage-1 read)
  logic        wb_en;
  logic        st_en;
  logic [WA_W-1:0] st_wa;
  logic [1:0]  st_bo;

  always_comb begin
    op = ins2[6:0]; rd = ins2[11:7]; f3 = ins2[14:12];
    rs1 = ins2[19:15]; rs2 = ins2[24:20]; f7 = ins2[31:25];
    a = (rs1 == 5'd0 || !fa2) ? 32'd0 : ra2;
    b = (rs2 == 5'd0 || !fb2) ? 32'd0 : rb2;
    imm_i = {{20{ins2[31]}}, ins2[31:20]};
    imm_s = {{20{ins2[31]}}, ins2[31:25], ins2[11:7]};
    imm_b = {{19{ins2[31]}}, ins2[31], ins2[7], ins2[30:25], ins2[11:8], 1'b0};
    imm_j = {{11{ins2[31]}}, ins2[31], ins2[19:12], ins2[20], ins2[30:21], 1'b0};
    imm_u = {ins2[31:12], 12'd0};
    alt = ins2[30];
    isreg = (op == OP_REG);
    alu_b = isreg ? b : imm_i;
    sh = alu_b[4:0];
    sh_x = $signed({alt & a[31], a}) >>> sh;
    sh_r = sh_x[31:0];
    ok = 1'b1; wr = 1'b0; memw = 1'b0; taken = 1'b0; val = '0;
    nxt = pc2 + 32'd4;
    st_off = a + imm_s - MEM_BASE;
    // lanes in memory order, rotated down so the byte at the load offset is lowest
    for (int k = 0; k < 4; k++)
      lane_w[8*k +: 8] = fwm2[k] ? fwd2[8*k +: 8] : lw2[8*k +: 8];
    ldpair = {lane_w, lane_w} >> {bo2, 3'b000};
    ldv = ldpair[31:0];
    case (op)
      OP_LOAD: begin
        if (f3 == F3_W) begin val = ldv; wr = 1'b1; end else ok = 1'b0;
      end
      OP_IMM, OP_REG: begin
        if (isreg && !(f7 == 7'h00 || f7 == 7'h20) && f3 == F3_ADD) ok = 1'b0;
        case (f3)
          F3_ADD:  val = (isreg && alt) ? a - alu_b : a + alu_b;
          F3_SLL:  val = a << sh;
          F3_SLT:  val = {31'd0, $signed(a) < $signed(alu_b)};
          F3_SLTU: val = {31'd0, a < alu_b};
          F3_XOR:  val = a ^ alu_b;
          F3_SR:   val = alt ? sh_r : a >> sh;
          F3_OR:   val = a | alu_b;
          default: val = a & alu_b;
        endcase
        wr = ok;
      end
      OP_AUIPC: begin val = pc2 + imm_u; wr = 1'b1; end
      OP_LUI:   begin val = imm_u; wr = 1'b1; end
      OP_STORE: begin
        if (f3 == F3_W) memw = (st_off <= 32'(MEM_BYTES - 4)); else ok = 1'b0;
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ: taken = (a == b);
          F3_BNE: taken = (a != b);
          F3_BLT: taken = $signed(a) < $signed(b);
          F3_BGE: taken = !($signed(a) < $signed(b));
          default: ok = 1'b0;
        endcase
        if (taken && ok) nxt = pc2 + imm_b;
      end
      OP_JALR: begin nxt = (a + imm_i) & 32'hFFFF_FFFE; val = pc2 + 32'd4; wr = 1'b1; end
      OP_JAL:  begin nxt = pc2 + imm_j; val = pc2 + 32'd4; wr = 1'b1; end
      default: ok = 1'b0;
    endcase
    if (!ok) begin wr = 1'b0; memw = 1'b0; nxt = pc2 + 32'd4; end
    if (rd == 5'd0) wr = 1'b0;
    wb_en = v2 && advance && wr;
    st_en = v2 && advance && memw;
    st_wa = st_off[MA_W-1:2];
    st_bo = st_off[1:0];
  end

  // store bytes rotated onto their lanes; lanes below the offset go to the next word
  logic [63:0] st_pair;
  logic [31:0] st_word;
  logic [WA_W-1:0] st_wa1;
  assign st_pair = {b, b} << {st_bo, 3'b000};
  assign st_word = st_pair[63:32];
  assign st_wa1  = st_wa + WA_W'(1);

  // ---------------- stage 1 reads ----------------
  logic [31:0] in_ins, in_a_addr_calc;
  logic [4:0]  r1, r2;
  logic [WA_W-1:0] la0, la1;
  logic [1:0]  ld_bo;
  assign in_ins = s_axis_tdata;
  assign r1 = in_ins[19:15];
  assign r2 = in_ins[24:20];
  // the load address uses the forwarded rs1 so the memory read starts in stage 1
  logic [31:0] fwd_a;
  assign fwd_a = (wb_en && rd == r1) ? val : ((rf_vld[r1]) ? rf[r1] : 32'd0);
  assign in_a_addr_calc = fwd_a + {{20{in_ins[31]}}, in_ins[31:20]} - MEM_BASE;
  assign la0 = in_a_addr_calc[MA_W-1:2];
  assign la1 = la0 + WA_W'(1);
  assign ld_bo = in_a_addr_calc[1:0];

  // per-lane word addresses for the load read and the store write
  logic [3:0][WA_W-1:0] lra, swa;
  logic [3:0]           fw_hit;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lra[k] = (2'(k) < ld_bo) ? la1 : la0;
      swa[k] = (2'(k) < st_bo) ? st_wa1 : st_wa;
      fw_hit[k] = st_en && (swa[k] == lra[k]);
    end
  end

  // stage-1 register; rf read is a direct array read with forwarding
  always_ff @(posedge clk) begin
    if (advance) begin
      ins2 <= in_ins;
      ra2  <= fwd_a;
      fa2  <= 1'b1;
      rb2  <= (wb_en && rd == r2) ? val : rf[r2];
      fb2  <= (wb_en && rd == r2) ? 1'b1 : rf_vld[r2];
      bo2  <= ld_bo;
      lw2  <= {dm3[lra[3]], dm2[lra[2]], dm1[lra[1]], dm0[lra[0]]};
      fwm2 <= fw_hit;
      fwd2 <= st_word;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (st_en) begin
      dm0[swa[0]] <= st_word[7:0];
      dm1[swa[1]] <= st_word[15:8];
      dm2[swa[2]] <= st_word[23:16];
      dm3[swa[3]] <= st_word[31:24];
    end
    if (wb_en) rf[rd] <= val;
  end

  // pc of the incoming item: next_pc of the item in stage 2 if any
  logic [31:0] pc_cur;
  assign pc_cur = (v2) ? nxt : pc;

  // control and pc
  result_t res;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0; pc <= '0; m_axis_tvalid <= 1'b0; rf_vld <= '0;
    end else begin
      if (wb_en) rf_vld[rd] <= 1'b1;
      if (advance) begin
        v2 <= acc;
        if (v2) m_axis_tvalid <= 1'b1;
        else    m_axis_tvalid <= 1'b0;
      end
      if (v2 && advance) pc <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) pc2 <= pc_cur;
  end

  always_ff @(posedge clk) begin
    if (advance && v2) m_axis_tdata <= res;
  end
  always_comb begin
    res = '0;
    res.pc = pc2;
    res.next_pc = nxt;
    res.wb_valid = wr;
    res.wb_index = wr ? rd : 5'd0;
    res.wb_value = wr ? val : 32'd0;
    res.mem_written = memw;
    res.unknown_op = !ok;
  end
endmodule
`default_nettype wire

FILE: rtl/core/rv32_checker.sv
`default_nettype none
module rv32_checker (
  input wire logic clk, rst,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid, m_axis_tready,
  input wire logic [111:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)) else $error("hold");
  a_noidx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[69:65] == 5'd0) else $error("idx");
  a_x0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[69:65] != 5'd0) else $error("x0");
  a_unk: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[103] |-> !m_axis_tdata[64] && !m_axis_tdata[102]) else $error("unk");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready) else $error("rdy");
endmodule
bind rv32i_subset_instruction_step rv32_checker u_chk (.*);
`default_nettype wire

FILE: sim/tb_rv32i_subset_instruction_step.sv
`timescale 1ns / 1ps
module tb_rv32i_subset_instruction_step;
  import rv32_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;    // instr
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;    // pc, next_pc, wb_valid, wb_index, wb_value,
                                 // mem_written, unknown_op, pad

  rv32i_subset_instruction_step dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // 4 ns clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // ---------------------------------------------------------------------------
  // Architectural shadow of the core: register file, pc, written memory bytes
  // ---------------------------------------------------------------------------
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic [7:0]  dmem_bytes [int unsigned];   // only bytes ever stored
  int unsigned stored_offsets [$];          // offsets of successful sw
  result_t     pending_results [$];
  int          fail_count;

  function automatic logic [31:0] sx12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [31:0] alu_result(logic [2:0] f3, logic alt, logic allow_sub,
                                             logic [31:0] a, logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      F3_ADD:  return (allow_sub && alt) ? a - b : a + b;
      F3_SLL:  return a << sh;
      F3_SLT:  return {31'd0, signed_less(a, b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? $unsigned($signed(a) >>> sh) : a >> sh;
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Executes one instruction on the shadow state, returns the result it should produce
  function automatic result_t exec_instr(logic [31:0] ins);
    result_t     r;
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, nxt, val, off;
    logic        ok, wr, memw, taken, alt;
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
    rs1 = ins[19:15]; rs2 = ins[24:20]; f7 = ins[31:25];
    a = arch_regs[rs1]; b = arch_regs[rs2];
    imm_i = sx12(ins[31:20]);
    imm_s = sx12({ins[31:25], ins[11:7]});
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    imm_u = {ins[31:12], 12'd0};
    alt = ins[30];
    nxt = arch_pc + 32'd4;
    ok = 1'b1; wr = 1'b0; memw = 1'b0; taken = 1'b0; val = '0;
    case (op)
      OP_LOAD: begin
        if (f3 == F3_W) begin
          off = (a + imm_i - MEM_BASE) % MEM_BYTES;
          for (int k = 0; k < 4; k++) begin
            int unsigned idx;
            idx = (off + k) % MEM_BYTES;
            val[8*k +: 8] = dmem_bytes.exists(idx) ? dmem_bytes[idx] : 8'h00;
          end
          wr = 1'b1;
        end else ok = 1'b0;
      end
      OP_IMM: begin
        val = alu_result(f3, (f3 == F3_SR) && alt, 1'b0, a, imm_i);
        wr = 1'b1;
      end
      OP_AUIPC: begin val = arch_pc + imm_u; wr = 1'b1; end
      OP_STORE: begin
        if (f3 == F3_W) begin
          off = a + imm_s - MEM_BASE;
          if (off <= MEM_BYTES - 4) begin
            for (int k = 0; k < 4; k++) dmem_bytes[off + k] = b[8*k +: 8];
            stored_offsets.push_back(off);
            memw = 1'b1;
          end
        end else ok = 1'b0;
      end
      OP_REG: begin
        if (f3 == F3_ADD && f7 != 7'h00 && f7 != 7'h20) ok = 1'b0;
        else begin
          val = alu_result(f3, alt, 1'b1, a, b);
          wr = 1'b1;
        end
      end
      OP_LUI: begin val = imm_u; wr = 1'b1; end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = signed_less(a, b);
          F3_BGE:  taken = !signed_less(a, b);
          default: ok = 1'b0;
        endcase
        if (taken) nxt = arch_pc + imm_b;
      end
      OP_JALR: begin
        nxt = (a + imm_i) & 32'hFFFF_FFFE;
        val = arch_pc + 32'd4; wr = 1'b1;
      end
      OP_JAL: begin
        nxt = arch_pc + imm_j;
        val = arch_pc + 32'd4; wr = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin wr = 1'b0; memw = 1'b0; nxt = arch_pc + 32'd4; end
    if (rd == 5'd0) wr = 1'b0;
    if (wr) arch_regs[rd] = val;
    r = '0;
    r.pc = arch_pc;
    r.next_pc = nxt;
    r.wb_valid = wr;
    r.wb_index = wr ? rd : 5'd0;
    r.wb_value = wr ? val : 32'd0;
    r.mem_written = memw;
    r.unknown_op = !ok;
    arch_pc = nxt;
    return r;
  endfunction

  // A load may only touch bytes that were stored before
  function automatic logic load_is_safe(logic [31:0] ins);
    logic [31:0] off;
    if (ins[6:0] != OP_LOAD || ins[14:12] != F3_W) return 1'b1;
    off = (arch_regs[ins[19:15]] + sx12(ins[31:20]) - MEM_BASE) % MEM_BYTES;
    for (int k = 0; k < 4; k++)
      if (!dmem_bytes.exists((off + k) % MEM_BYTES)) return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: bursts with random gaps
  // ---------------------------------------------------------------------------
  int  burst_left;
  logic gaps_on;

  // called and returns at a falling edge
  task automatic send_instr(logic [31:0] ins);
    if (gaps_on && burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(3, 12) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ins;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(exec_instr(ins));
    @(negedge clk);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_s(logic [4:0] rs1, logic [4:0] rs2, logic [11:0] imm);
    return {imm[11:5], rs2, rs1, F3_W, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_u(logic [6:0] op, logic [4:0] rd, logic [19:0] imm);
    return {imm, rd, op};
  endfunction

  // Finds a base register reaching addr with a 12-bit offset; loads one with lui if none does
  task automatic reach_addr(logic [31:0] addr, output logic [4:0] base, output logic [11:0] ofs);
    logic [31:0] d, hi;
    int start;
    start = $urandom_range(1, 31);
    for (int i = 0; i < 31; i++) begin
      logic [4:0] r;
      r = 5'((start + i - 1) % 31 + 1);
      d = addr - arch_regs[r];
      if ($signed(d) >= -2048 && $signed(d) <= 2047) begin
        base = r; ofs = d[11:0];
        return;
      end
    end
    base = 5'($urandom_range(1, 31));
    hi = (addr + 32'h800) & 32'hFFFF_F000;
    send_instr(enc_u(OP_LUI, base, hi[31:12]));
    d = addr - hi;
    ofs = d[11:0];
  endtask

  task automatic random_store();
    logic [31:0] off;
    logic [4:0]  base;
    logic [11:0] ofs;
    case ($urandom_range(0, 19))
      0:       off = MEM_BYTES - 4 + $urandom_range(0, 3);      // top edge, in or partly out
      1:       off = $urandom_range(MEM_BYTES, MEM_BYTES + 4096); // beyond memory
      2:       off = -$urandom_range(1, 2048);                  // below base
      default: off = $urandom_range(0, 511);
    endcase
    reach_addr(MEM_BASE + off, base, ofs);
    send_instr(enc_s(base, 5'($urandom_range(0, 31)), ofs));
  endtask

  task automatic random_load();
    logic [31:0] off;
    logic [4:0]  base;
    logic [11:0] ofs;
    logic [31:0] probe;
    if (stored_offsets.size() == 0) random_store();
    if (stored_offsets.size() == 0) return;
    off = stored_offsets[$urandom_range(0, stored_offsets.size() - 1)];
    probe = (off + $urandom_range(0, 6) - 3) % MEM_BYTES;
    if (dmem_bytes.exists(probe) && dmem_bytes.exists((probe + 1) % MEM_BYTES) &&
        dmem_bytes.exists((probe + 2) % MEM_BYTES) && dmem_bytes.exists((probe + 3) % MEM_BYTES))
      off = probe;
    // aliases above the memory size wrap back onto the same bytes
    reach_addr(MEM_BASE + off + ($urandom_range(0, 3) << 16), base, ofs);
    send_instr(enc_i(OP_LOAD, F3_W, 5'($urandom_range(0, 31)), base, ofs));
  endtask

  task automatic random_alu();
    logic [2:0] f3;
    logic [6:0] f7;
    f3 = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) begin
      send_instr(enc_i(OP_IMM, f3, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       12'($urandom)));
    end else begin
      f7 = $urandom_range(0, 7) == 0 ? 7'($urandom) : ($urandom_range(0, 1) ? 7'h20 : 7'h00);
      send_instr(enc_r(f7, f3, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31))));
    end
  endtask

  task automatic random_flow();
    case ($urandom_range(0, 4))
      0: send_instr(enc_u(OP_JAL, 5'($urandom_range(0, 31)), 20'($urandom)));
      1: send_instr(enc_i(OP_JALR, 3'($urandom), 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)), 12'($urandom)));
      2: send_instr(enc_u($urandom_range(0, 1) ? OP_LUI : OP_AUIPC,
                          5'($urandom_range(0, 31)), 20'($urandom)));
      default: send_instr(enc_b(3'($urandom), 5'($urandom_range(0, 31)),
                                5'($urandom_range(0, 31)), 13'($urandom)));
    endcase
  endtask

  // Raw word; a load that would hit unwritten bytes gets a bad funct3 instead
  task automatic random_noise();
    logic [31:0] ins;
    ins = $urandom;
    if (!load_is_safe(ins)) ins[14:12] = F3_SLTU;
    send_instr(ins);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: own stall pattern, plus a long hold-off on demand
  // ---------------------------------------------------------------------------
  logic hold_req;
  int   hold_left;
  int   pattern_left;
  int   pattern_kind;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
    end
    if (pattern_left == 0) begin
      pattern_kind = $urandom_range(0, 3);
      pattern_left = $urandom_range(16, 96);
    end else pattern_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (pattern_kind)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h", field, got, want);
    fail_count++;
  endtask

  // Compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_t got, want;
      got = result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result pc", got.pc, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.pc !== want.pc) report_mismatch("pc", got.pc, want.pc);
        if (got.next_pc !== want.next_pc) report_mismatch("next_pc", got.next_pc, want.next_pc);
        if (got.wb_valid !== want.wb_valid)
          report_mismatch("wb_valid", 32'(got.wb_valid), 32'(want.wb_valid));
        if (got.wb_index !== want.wb_index)
          report_mismatch("wb_index", 32'(got.wb_index), 32'(want.wb_index));
        if (got.wb_value !== want.wb_value)
          report_mismatch("wb_value", got.wb_value, want.wb_value);
        if (got.mem_written !== want.mem_written)
          report_mismatch("mem_written", 32'(got.mem_written), 32'(want.mem_written));
        if (got.unknown_op !== want.unknown_op)
          report_mismatch("unknown_op", 32'(got.unknown_op), 32'(want.unknown_op));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes, each operation, store range limits, load wrap, x0 and unsupported words
  task automatic test_directed();
    send_instr(enc_u(OP_LUI, 5'd1, 20'h10000));            // x1 = memory base
    send_instr(enc_i(OP_IMM, F3_ADD, 5'd2, 5'd0, 12'hFFF)); // x2 = -1
    send_instr(enc_s(5'd1, 5'd2, 12'd0));                   // word at offset 0
    send_instr(enc_i(OP_LOAD, F3_W, 5'd31, 5'd1, 12'd0));
    send_instr(enc_u(OP_LUI, 5'd3, 20'h10010));             // x3 = base + MEM_BYTES
    send_instr(enc_s(5'd3, 5'd31, 12'hFFC));                // last word in memory
    send_instr(enc_i(OP_LOAD, F3_W, 5'd4, 5'd3, 12'hFFE));  // wraps to offset 0
    send_instr(enc_s(5'd3, 5'd2, 12'hFFE));                 // runs off the top: ignored
    send_instr(enc_s(5'd1, 5'd2, 12'hFFC));                 // below base: ignored
    send_instr(enc_u(OP_LUI, 5'd5, 20'h80000));             // most negative
    for (int f = 0; f < 8; f++) begin
      send_instr(enc_r(7'h00, 3'(f), 5'd6, 5'd5, 5'd2));
      send_instr(enc_i(OP_IMM, 3'(f), 5'd7, 5'd5, (f == F3_SR) ? 12'h41F : 12'h7FF));
    end
    send_instr(enc_r(7'h20, F3_ADD, 5'd8, 5'd5, 5'd2));     // sub
    send_instr(enc_r(7'h20, F3_SR, 5'd8, 5'd5, 5'd4));      // sra
    send_instr(enc_r(7'h01, F3_ADD, 5'd9, 5'd5, 5'd2));     // bad funct7
    send_instr(enc_i(OP_IMM, F3_ADD, 5'd0, 5'd2, 12'h123)); // write to x0 dropped
    send_instr(enc_b(F3_BEQ, 5'd2, 5'd31, 13'h1FF0));
    send_instr(enc_b(F3_BNE, 5'd2, 5'd0, 13'h0FFE));
    send_instr(enc_b(F3_BLT, 5'd5, 5'd0, 13'h0008));
    send_instr(enc_b(F3_BGE, 5'd0, 5'd5, 13'h1000));
    send_instr(enc_b(3'd2, 5'd0, 5'd0, 13'h0010));          // unsupported branch
    send_instr(enc_u(OP_JAL, 5'd10, 20'hFFFFF));
    send_instr(enc_i(OP_JALR, 3'd0, 5'd11, 5'd2, 12'h7FF)); // even target, bit 0 already clear
    send_instr(enc_u(OP_AUIPC, 5'd12, 20'hFFFFF));
    send_instr(enc_i(OP_LOAD, 3'd0, 5'd13, 5'd1, 12'd0));   // lb: unsupported
    send_instr(32'hFFFF_FFFF);                              // unknown opcode
    idle_sender();
  endtask

  // Mostly well-formed programs; a share of raw words
  task automatic test_random();
    for (int n = 0; n < 1000; n++) begin
      gaps_on = (n % 300) < 220;    // stretches with no sender gaps
      case ($urandom_range(0, 9))
        0, 1, 2: random_alu();
        3:       random_store();
        4, 5:    random_load();
        6:       random_flow();
        7:       send_instr(enc_i(OP_IMM, F3_ADD, 5'($urandom_range(1, 31)),
                                  5'($urandom_range(0, 31)), 12'($urandom)));
        default: random_noise();
      endcase
    end
    gaps_on = 1'b1;
    idle_sender();
  endtask

  // Receiver holds off for a long time while requests keep coming
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) begin
      if (n % 3 == 0) random_store();
      else if (n % 3 == 1) random_load();
      else random_alu();
    end
    gaps_on = 1'b1;
    idle_sender();
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    pattern_left  = 0;
    pattern_kind  = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    fail_count    = 0;
    arch_pc       = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random();
    test_backpressure();
    drain_results();

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rv32_pkg.sv
rtl/core/rv32i_subset_instruction_step.sv
rtl/core/rv32_checker.sv
sim/tb_rv32i_subset_instruction_step.sv
